// ----- rtl/core/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// shared types, widths and constants of the multichannel scalar kalman filter
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int CHAN_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int K_W       = 16;
    localparam int DEN_W     = DATA_W + 1;
    localparam int DIV_CNT_W = $clog2(K_W);
    localparam int MUL_A_W   = K_W + 2;
    localparam int MUL_B_W   = DATA_W + 2;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    localparam int CHANNELS_DEFAULT = 16;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST      = 32'd8192;
    localparam logic [DATA_W-1:0] SENSOR_NOISE_RST       = 32'd20972;
    localparam logic [DATA_W-1:0] INITIAL_COVARIANCE_RST = 32'd1966080;
    localparam logic [DATA_W-1:0] INITIAL_ESTIMATE_RST   = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE,
        REG_SENSOR_NOISE,
        REG_INITIAL_COVARIANCE,
        REG_INITIAL_ESTIMATE
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PRED,
        ST_LOAD,
        ST_DIV,
        ST_MUL_GAIN,
        ST_MUL_COV,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- rtl/core/skf_div.sv -----
// ----------------------------------------------------------------------------
// skf_div
// restoring divider for the gain, one quotient bit per cycle
// ----------------------------------------------------------------------------
module skf_div
    import skf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [K_W-1:0]   quotient,
    output div_status_t      status
);

    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [K_W-1:0]       q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic             last_step;

    assign shifted   = {rem_reg, 1'b0};
    assign trial     = shifted - {1'b0, den_reg};
    assign fits      = shifted >= {1'b0, den_reg};
    assign rem_next  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    assign last_step = cnt_reg == DIV_CNT_W'(K_W - 1);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            den_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[K_W-2:0], fits};
        end
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- rtl/core/skf_mul.sv -----
// ----------------------------------------------------------------------------
// skf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module skf_mul
    import skf_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

// ----- rtl/core/scalar_kalman_filter_multichannel_unit.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_multichannel_unit
// per-channel 1-d kalman filter with q16.16 state and q0.16 gain
// ----------------------------------------------------------------------------
// Each request carries a channel number and a measurement. The block reads
// the channel's covariance and estimate (or the configured initial values on
// the channel's first request), predicts p1 = p + q with saturation, forms
// the gain k = p1 / (p1 + r) on a bit-serial divider, then updates the
// estimate and covariance on one shared multiplier. A request passes the
// read, prediction, load, division, two multiply, write and output states
// in turn; in_ready is high only in the idle state, so no request is taken
// until the last has left the output state. A finished result waits in an
// output register, so the next request may enter while the last is still
// unread. Requests on a channel at or above CHANNELS are taken and dropped.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_multichannel_unit
    import skf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CHAN_W-1:0]        channel,
    input  logic signed [DATA_W-1:0] measurement,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CHAN_W-1:0]        out_channel,
    output logic signed [DATA_W-1:0] estimate,
    output logic [DATA_W-1:0]        covariance
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W  = ADDR_W + CHAN_W;

    // configuration
    logic [DATA_W-1:0]        q_reg;
    logic [DATA_W-1:0]        r_reg;
    logic [DATA_W-1:0]        p0_reg;
    logic signed [DATA_W-1:0] x0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= PROCESS_NOISE_RST;
            r_reg  <= SENSOR_NOISE_RST;
            p0_reg <= INITIAL_COVARIANCE_RST;
            x0_reg <= INITIAL_ESTIMATE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PROCESS_NOISE:      q_reg  <= cfg_data;
                REG_SENSOR_NOISE:       r_reg  <= cfg_data;
                REG_INITIAL_COVARIANCE: p0_reg <= cfg_data;
                REG_INITIAL_ESTIMATE:   x0_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // sequencer
    state_t state_reg;
    state_t state_next;

    div_status_t div_status;
    logic [K_W-1:0] div_quotient;

    logic             accept;
    logic             in_range;
    logic [EXT_W-1:0] chan_ext;
    logic             out_load;
    logic             div_start;
    logic             mem_we;

    assign accept   = in_valid && in_ready;
    assign chan_ext = EXT_W'(channel);
    assign in_range = chan_ext < EXT_W'(CHANNELS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_range)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:     state_next = ST_PRED;
            ST_PRED:     state_next = ST_LOAD;
            ST_LOAD:     state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN: state_next = ST_MUL_COV;
            ST_MUL_COV:  state_next = ST_WRITE;
            ST_WRITE:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready  = 1'b1;
            ST_LOAD:  div_start = 1'b1;
            ST_WRITE: mem_we    = 1'b1;
            ST_OUT:   out_load  = !out_valid || out_ready;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // channel state
    logic [DATA_W-1:0]   cov_mem [CHANNELS];
    logic [DATA_W-1:0]   est_mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [DATA_W-1:0]   cov_rd_reg;
    logic [DATA_W-1:0]   est_rd_reg;
    logic                hit_reg;

    logic [ADDR_W-1:0]        addr_reg;
    logic [CHAN_W-1:0]        chan_reg;
    logic signed [DATA_W-1:0] z_reg;
    logic [DATA_W-1:0]        p1_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] x1_reg;
    logic [K_W-1:0]           k_reg;
    logic                     den_zero_reg;
    logic [DATA_W-1:0]        p2_reg;

    logic signed [PROD_W-1:0] prod;
    logic [DATA_W-1:0]        prod_q;

    assign prod_q = prod[FRAC_W+DATA_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cov_mem[addr_reg] <= prod_q;
            est_mem[addr_reg] <= x1_reg;
        end
        cov_rd_reg <= cov_mem[addr_reg];
        est_rd_reg <= est_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            hit_reg <= valid_reg[addr_reg];
            if (mem_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // prediction and divider operands
    logic [DATA_W-1:0] p_sel;
    logic [DATA_W:0]   p_sum;
    logic [DATA_W-1:0] p1_sat;
    logic [DEN_W-1:0]  den;

    assign p_sel  = hit_reg ? cov_rd_reg : p0_reg;
    assign p_sum  = {1'b0, p_sel} + {1'b0, q_reg};
    assign p1_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
    assign den    = {1'b0, p1_reg} + {1'b0, r_reg};

    skf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b0, p1_reg}),
        .divisor  (den),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [K_W:0]              k_inv;

    assign k_inv = (K_W+1)'(1 << K_W) - {1'b0, k_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_GAIN:
            begin
                mul_a = {2'b00, k_reg};
                mul_b = {{2{z_reg[DATA_W-1]}}, z_reg} - {{2{x_reg[DATA_W-1]}}, x_reg};
            end
            ST_MUL_COV:
            begin
                mul_a = {1'b0, k_inv};
                mul_b = {2'b00, p1_reg};
            end
            default: ;
        endcase
    end

    skf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chan_reg <= channel;
            z_reg    <= measurement;
            addr_reg <= chan_ext[ADDR_W-1:0];
        end
        if (state_reg == ST_PRED)
        begin
            p1_reg <= p1_sat;
            x_reg  <= hit_reg ? est_rd_reg : x0_reg;
        end
        if (state_reg == ST_LOAD)
        begin
            den_zero_reg <= den == '0;
        end
        if (state_reg == ST_DIV && div_status.done)
        begin
            k_reg <= den_zero_reg ? '0 : div_quotient;
        end
        if (state_reg == ST_MUL_COV)
        begin
            x1_reg <= x_reg + prod_q;
        end
        if (state_reg == ST_WRITE)
        begin
            p2_reg <= prod_q;
        end
    end

    // result register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_channel <= chan_reg;
            estimate    <= x1_reg;
            covariance  <= p2_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the gain step");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_status.busy)
        else $error("request taken while the divider is busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> prod[PROD_W-1:FRAC_W+DATA_W] == '0)
        else $error("updated covariance out of range");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multichannel scalar kalman filter
// ----------------------------------------------------------------------------
// Runs a short directed plan of register writes and requests covering the
// corners of the filter: saturation, zero sensor noise, gain cap, zero gain,
// and field extremes. A random part follows, mostly tracking a slowly
// moving value per channel, over several register settings and idle
// patterns. Each estimate is predicted by a fixed-point filter model in the
// bench, or given in the plan, and compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
    import skf_pkg::*;

    localparam int CHANNELS      = CHANNELS_DEFAULT;
    localparam int BLOCK_LATENCY = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 240;
    localparam int PHASES        = 6;
    localparam int PLAN_ROWS     = 30;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] est;
        logic [DATA_W-1:0] cov;
    } filter_out_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        cfg_reg_t          regsel;
        logic [CHAN_W-1:0] ch;
        logic [DATA_W-1:0] value;
        bit                known;
        filter_out_t       want;
    } plan_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [CHAN_W-1:0]        channel;
    logic signed [DATA_W-1:0] measurement;
    logic                     out_valid;
    logic                     out_ready;
    logic [CHAN_W-1:0]        out_channel;
    logic signed [DATA_W-1:0] estimate;
    logic [DATA_W-1:0]        covariance;

    // filter model state and register copies
    logic [DATA_W-1:0] track_cov [CHANNELS];
    logic [DATA_W-1:0] track_est [CHANNELS];
    bit                track_seen [CHANNELS];
    logic [DATA_W-1:0] q_noise;
    logic [DATA_W-1:0] r_noise;
    logic [DATA_W-1:0] p_start;
    logic [DATA_W-1:0] x_start;

    filter_out_t pending_estimates [$];
    plan_row_t   plan [PLAN_ROWS];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int requests_sent;
    int estimates_checked;
    int mismatches;
    int settings_used;

    scalar_kalman_filter_multichannel_unit #(
        .CHANNELS (CHANNELS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .estimate    (estimate),
        .covariance  (covariance)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #12000000;
        $display("tb_top: errors");
        $finish;
    end

    // one filter step: time update, gain, measurement update
    function automatic filter_out_t kalman_step(input logic [CHAN_W-1:0] ch,
                                                input logic signed [DATA_W-1:0] z);
        logic [DATA_W-1:0]        p;
        logic signed [DATA_W-1:0] x;
        logic [DATA_W:0]          p_pred;
        logic [DATA_W:0]          den;
        logic [63:0]              gain;
        logic [63:0]              p_new;
        longint                   diff;
        longint                   corr;
        longint                   x_new;
        filter_out_t              res;
        p = track_seen[ch] ? track_cov[ch] : p_start;
        x = track_seen[ch] ? track_est[ch] : x_start;
        p_pred = {1'b0, p} + {1'b0, q_noise};
        if (p_pred[DATA_W])
            p_pred = {1'b0, {DATA_W{1'b1}}};
        den = p_pred + {1'b0, r_noise};
        if (den == '0)
            gain = 64'd0;
        else
            gain = ({31'b0, p_pred} << FRAC_W) / {31'b0, den};
        if (gain > 64'd65535)
            gain = 64'd65535;
        diff  = longint'(z) - longint'(x);
        corr  = longint'(gain) * diff;
        x_new = longint'(x) + (corr >>> FRAC_W);
        p_new = ((64'd65536 - gain) * {31'b0, p_pred}) >> FRAC_W;
        track_cov[ch]  = p_new[DATA_W-1:0];
        track_est[ch]  = x_new[DATA_W-1:0];
        track_seen[ch] = 1'b1;
        res.chan = ch;
        res.est  = x_new[DATA_W-1:0];
        res.cov  = p_new[DATA_W-1:0];
        return res;
    endfunction

    function automatic plan_row_t cfg_row(input cfg_reg_t r, input logic [DATA_W-1:0] v);
        plan_row_t row;
        row.kind   = ROW_CFG;
        row.regsel = r;
        row.ch     = '0;
        row.value  = v;
        row.known  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic plan_row_t item_row(input logic [CHAN_W-1:0] ch,
                                           input logic [DATA_W-1:0] z);
        plan_row_t row;
        row.kind   = ROW_ITEM;
        row.regsel = REG_PROCESS_NOISE;
        row.ch     = ch;
        row.value  = z;
        row.known  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic plan_row_t known_row(input logic [CHAN_W-1:0] ch,
                                            input logic [DATA_W-1:0] z,
                                            input logic [DATA_W-1:0] est,
                                            input logic [DATA_W-1:0] cov);
        plan_row_t row;
        row = item_row(ch, z);
        row.known = 1'b1;
        row.want  = '{chan: ch, est: est, cov: cov};
        return row;
    endfunction

    task automatic note_mismatch(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    always @(posedge clk)
    begin
        filter_out_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_estimates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("estimate on channel %0d with no request outstanding",
                             out_channel);
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (out_channel !== want.chan)
                    note_mismatch("out_channel", DATA_W'(want.chan), DATA_W'(out_channel));
                if (estimate !== want.est)
                    note_mismatch("estimate", want.est, estimate);
                if (covariance !== want.cov)
                    note_mismatch("covariance", want.cov, covariance);
                estimates_checked++;
            end
        end
    end

    // output side: random back-pressure, plus one long hold on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic [CHAN_W-1:0] ch,
                                input logic signed [DATA_W-1:0] z,
                                input bit known, input filter_out_t want);
        filter_out_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        channel     <= ch;
        measurement <= z;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predicted = kalman_step(ch, z);
        pending_estimates.push_back(known ? want : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_PROCESS_NOISE:      q_noise = value;
            REG_SENSOR_NOISE:       r_noise = value;
            REG_INITIAL_COVARIANCE: p_start = value;
            REG_INITIAL_ESTIMATE:   x_start = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_settings(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
                                    input logic [DATA_W-1:0] p0,
                                    input logic [DATA_W-1:0] x0);
        wait_drained();
        write_register(REG_PROCESS_NOISE, q);
        write_register(REG_SENSOR_NOISE, r);
        write_register(REG_INITIAL_COVARIANCE, p0);
        write_register(REG_INITIAL_ESTIMATE, x0);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic signed [DATA_W-1:0] truth [CHANNELS];
        logic signed [DATA_W-1:0] z;
        logic [CHAN_W-1:0]        ch;
        bit                       cfg_open;
        int                       pick;

        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_PROCESS_NOISE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        channel     = '0;
        measurement = '0;
        hold_req    = 1'b0;
        cfg_open    = 1'b0;
        q_noise     = PROCESS_NOISE_RST;
        r_noise     = SENSOR_NOISE_RST;
        p_start     = INITIAL_COVARIANCE_RST;
        x_start     = INITIAL_ESTIMATE_RST;
        send_idle_pct = 6;
        recv_idle_pct = 62;
        settings_used = 1;
        foreach (track_seen[i])
        begin
            track_seen[i] = 1'b0;
            track_cov[i]  = '0;
            track_est[i]  = '0;
            truth[i]      = $urandom();
        end

        plan = '{
            // zero covariance and process noise: gain is zero, estimate holds
            cfg_row(REG_PROCESS_NOISE, 32'h0000_0000),
            cfg_row(REG_INITIAL_COVARIANCE, 32'h0000_0000),
            cfg_row(REG_INITIAL_ESTIMATE, 32'h7FFF_FFFF),
            known_row(4'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000),
            known_row(4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000),
            // zero sensor noise with zero denominator
            cfg_row(REG_SENSOR_NOISE, 32'h0000_0000),
            cfg_row(REG_INITIAL_ESTIMATE, 32'h8000_0000),
            known_row(4'd2, 32'h1234_5678, 32'h8000_0000, 32'h0000_0000),
            // zero sensor noise, gain capped
            cfg_row(REG_PROCESS_NOISE, 32'h0001_0000),
            known_row(4'd3, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001),
            item_row(4'd3, 32'h0001_0000),
            // covariance saturation, gain one half
            cfg_row(REG_PROCESS_NOISE, 32'hFFFF_FFFF),
            cfg_row(REG_SENSOR_NOISE, 32'hFFFF_FFFF),
            cfg_row(REG_INITIAL_COVARIANCE, 32'hFFFF_FFFF),
            known_row(4'd4, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF),
            known_row(4'd4, 32'h8000_0000, 32'hBFFF_FFFF, 32'h7FFF_FFFF),
            item_row(4'd1, 32'h0000_0000),
            // back to reset values
            cfg_row(REG_PROCESS_NOISE, PROCESS_NOISE_RST),
            cfg_row(REG_SENSOR_NOISE, SENSOR_NOISE_RST),
            cfg_row(REG_INITIAL_COVARIANCE, INITIAL_COVARIANCE_RST),
            cfg_row(REG_INITIAL_ESTIMATE, INITIAL_ESTIMATE_RST),
            item_row(4'd0, 32'h0000_0000),
            item_row(4'd0, 32'h0001_0000),
            item_row(4'd0, 32'h0001_0000),
            item_row(4'd5, 32'h7FFF_FFFF),
            item_row(4'd6, 32'h8000_0000),
            item_row(4'd15, 32'hFFFF_FFFF),
            item_row(4'd7, 32'h0000_8000),
            item_row(4'd8, 32'hFFFF_0000),
            item_row(4'd15, 32'h0012_3456)
        };

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                begin
                    wait_drained();
                    cfg_open = 1'b1;
                    settings_used++;
                end
                write_register(plan[i].regsel, plan[i].value);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_write <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_request(plan[i].ch, plan[i].value, plan[i].known, plan[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 62 : 0;
            recv_idle_pct = (phase < 2) ? 62 : (phase < 4) ? 6 : 0;
            case (phase)
                0:
                    program_settings(PROCESS_NOISE_RST, SENSOR_NOISE_RST,
                                     INITIAL_COVARIANCE_RST, INITIAL_ESTIMATE_RST);
                1, 5:
                    program_settings($urandom_range(0, 32'h0002_0000),
                                     $urandom_range(1, 32'h0010_0000),
                                     $urandom_range(0, 32'h0100_0000),
                                     $urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
                2:
                    program_settings(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                                     32'h8000_0000);
                3:
                    program_settings(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                                     32'h7FFF_FFFF);
                default:
                    program_settings($urandom(), $urandom(), $urandom(), $urandom());
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == 100)
                    hold_req = 1'b1;
                ch   = CHAN_W'($urandom_range(CHANNELS - 1));
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    // slowly moving target seen through noise
                    truth[ch] = truth[ch] + $urandom_range(0, 32'h2000) - 32'h1000;
                    z = truth[ch] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                end
                else if (pick < 90)
                    z = $urandom();
                else
                begin
                    case ($urandom_range(3))
                        0:       z = 32'h7FFF_FFFF;
                        1:       z = 32'h8000_0000;
                        2:       z = 32'h0000_0000;
                        default: z = 32'hFFFF_FFFF;
                    endcase
                end
                send_request(ch, z, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (2 * BLOCK_LATENCY) @(negedge clk);
        $display("summary: %0d requests under %0d register settings, %0d estimates checked",
                 requests_sent, settings_used, estimates_checked);
        $display("summary: saturation, zero sensor noise, gain cap and a long output hold run");
        if (mismatches == 0 && pending_estimates.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
